// File: rtl/gbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal package
// Item types, function and status codes, and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package gbt_pkg;

  localparam logic [1:0] FUNC_CLEAR = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_BFS   = 2'd2;
  localparam logic [1:0] FUNC_DFS   = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [6:0] VCOUNT_RESET = 7'd64;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] first_vertex;
    logic [5:0] second_vertex;
  } in_item_t;

  typedef struct packed {
    logic [5:0] visited_vertex;
    logic       last_of_run;
    logic [1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    HSEL_A,
    HSEL_B,
    HSEL_CUR
  } head_sel_e;

  typedef struct packed {
    logic       accept;
    logic       clear_graph;
    logic       status_ld;
    logic [1:0] status_val;
    logic       head_rd;
    head_sel_e  head_sel;
    logic       add_wr;
    logic       add_wr_b;
    logic       walk_init;
    logic       pop;
    logic       pool_rd_head;
    logic       pool_rd_link;
    logic       edge_proc;
    logic       emit_status;
    logic       emit_vertex;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       range_bad;
    logic       start_bad;
    logic       pool_full;
    logic       head_null;
    logic       link_null;
    logic       list_empty;
    logic       out_free;
  } dp_sts_t;

endpackage

// File: rtl/gbt_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal datapath
// Neighbor list heads, edge pool, visited marks, work list and result register.
// ----------------------------------------------------------------------------
module gbt_dp #(
  parameter int MAX_VERTICES      = 64,
  parameter int EDGE_POOL_ENTRIES = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbt_pkg::in_item_t   in_data_i,
  input  logic                cfg_write_i,
  input  logic [6:0]          cfg_data_i,
  input  gbt_pkg::dp_cmd_t    cmd_i,
  output gbt_pkg::dp_sts_t    sts_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output gbt_pkg::out_item_t  out_data_o
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int FW = $clog2(MAX_VERTICES + 1);
  localparam int PW = $clog2(EDGE_POOL_ENTRIES);
  localparam int LW = $clog2(EDGE_POOL_ENTRIES + 1);
  localparam logic [LW-1:0] LINK_NULL = LW'(EDGE_POOL_ENTRIES);

  logic [6:0]              vcount_q;
  logic [6:0]              act_cnt;
  logic [1:0]              func_q;
  logic [5:0]              a_q;
  logic [5:0]              b_q;
  logic [1:0]              status_q;

  logic [LW-1:0]           head_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] head_valid_q;
  logic [LW-1:0]           head_rd_q;
  logic                    head_vld_rd_q;
  logic [LW-1:0]           head_eff;
  logic [VW-1:0]           head_addr;

  logic [VW-1:0]           pool_nb_mem [EDGE_POOL_ENTRIES];
  logic [LW-1:0]           pool_link_mem [EDGE_POOL_ENTRIES];
  logic [VW-1:0]           nb_rd_q;
  logic [LW-1:0]           link_rd_q;
  logic [PW-1:0]           pool_addr;
  logic [LW-1:0]           pool_used_q;

  logic [MAX_VERTICES-1:0] visited_q;
  logic [VW-1:0]           work_mem [MAX_VERTICES];
  logic [VW-1:0]           work_rd_q;
  logic [FW-1:0]           front_q;
  logic [FW-1:0]           back_q;
  logic [FW-1:0]           back_m1;
  logic [VW-1:0]           work_addr;
  logic [VW-1:0]           cur_q;

  logic [VW-1:0]           add_owner;
  logic [VW-1:0]           add_nb;
  logic                    push_ok;
  logic                    is_dfs;

  logic                    out_valid_q;
  gbt_pkg::out_item_t      out_q;
  logic                    out_free;

  assign act_cnt   = (vcount_q > 7'(MAX_VERTICES)) ? 7'(MAX_VERTICES) : vcount_q;
  assign head_eff  = head_vld_rd_q ? head_rd_q : LINK_NULL;
  assign is_dfs    = (func_q == gbt_pkg::FUNC_DFS);
  assign back_m1   = back_q - FW'(1);
  assign work_addr = is_dfs ? back_m1[VW-1:0] : front_q[VW-1:0];
  assign pool_addr = cmd_i.pool_rd_head ? head_eff[PW-1:0] : link_rd_q[PW-1:0];
  assign add_owner = cmd_i.add_wr_b ? b_q[VW-1:0] : a_q[VW-1:0];
  assign add_nb    = cmd_i.add_wr_b ? a_q[VW-1:0] : b_q[VW-1:0];
  assign push_ok   = ({{(7-VW){1'b0}}, nb_rd_q} < act_cnt) && !visited_q[nb_rd_q]
                     && (back_q < FW'(MAX_VERTICES));
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (cmd_i.head_sel)
      gbt_pkg::HSEL_A:   head_addr = a_q[VW-1:0];
      gbt_pkg::HSEL_B:   head_addr = b_q[VW-1:0];
      gbt_pkg::HSEL_CUR: head_addr = work_rd_q;
      default:           head_addr = a_q[VW-1:0];
    endcase
  end

  always_comb begin
    sts_o.func       = func_q;
    sts_o.range_bad  = ({1'b0, a_q} >= act_cnt) || ({1'b0, b_q} >= act_cnt);
    sts_o.start_bad  = ({1'b0, a_q} >= act_cnt);
    sts_o.pool_full  = ({1'b0, pool_used_q} + (LW + 1)'(2)) > (LW + 1)'(EDGE_POOL_ENTRIES);
    sts_o.head_null  = (head_eff == LINK_NULL);
    sts_o.link_null  = (link_rd_q == LINK_NULL);
    sts_o.list_empty = (back_q == front_q);
    sts_o.out_free   = out_free;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q     <= gbt_pkg::VCOUNT_RESET;
      head_valid_q <= '0;
      visited_q    <= '0;
      pool_used_q  <= '0;
      front_q      <= '0;
      back_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_write_i) begin
        vcount_q <= cfg_data_i;
      end
      if (cmd_i.clear_graph) begin
        head_valid_q <= '0;
        visited_q    <= '0;
        pool_used_q  <= '0;
        front_q      <= '0;
        back_q       <= '0;
      end
      if (cmd_i.add_wr) begin
        head_valid_q[add_owner] <= 1'b1;
        pool_used_q             <= pool_used_q + LW'(1);
      end
      if (cmd_i.walk_init) begin
        // Only the start vertex is marked when a walk begins.
        visited_q <= {{(MAX_VERTICES-1){1'b0}}, 1'b1} << a_q[VW-1:0];
        front_q   <= '0;
        back_q    <= FW'(1);
      end
      if (cmd_i.pop) begin
        if (is_dfs) begin
          back_q <= back_m1;
        end else begin
          front_q <= front_q + FW'(1);
        end
      end
      if (cmd_i.edge_proc && push_ok) begin
        visited_q[nb_rd_q] <= 1'b1;
        back_q             <= back_q + FW'(1);
      end
      if (cmd_i.emit_status || cmd_i.emit_vertex) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers and memories.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q <= in_data_i.func;
      a_q    <= in_data_i.first_vertex;
      b_q    <= in_data_i.second_vertex;
    end
    if (cmd_i.status_ld) begin
      status_q <= cmd_i.status_val;
    end
    if (cmd_i.head_rd) begin
      head_rd_q     <= head_mem[head_addr];
      head_vld_rd_q <= head_valid_q[head_addr];
    end
    if (cmd_i.head_rd && (cmd_i.head_sel == gbt_pkg::HSEL_CUR)) begin
      cur_q <= work_rd_q;
    end
    if (cmd_i.add_wr) begin
      head_mem[add_owner]                <= pool_used_q;
      pool_nb_mem[pool_used_q[PW-1:0]]   <= add_nb;
      pool_link_mem[pool_used_q[PW-1:0]] <= head_eff;
    end
    if (cmd_i.pool_rd_head || cmd_i.pool_rd_link) begin
      nb_rd_q   <= pool_nb_mem[pool_addr];
      link_rd_q <= pool_link_mem[pool_addr];
    end
    if (cmd_i.walk_init) begin
      work_mem[0] <= a_q[VW-1:0];
    end
    if (cmd_i.edge_proc && push_ok) begin
      work_mem[back_q[VW-1:0]] <= nb_rd_q;
    end
    if (cmd_i.pop) begin
      work_rd_q <= work_mem[work_addr];
    end
    if (cmd_i.emit_status) begin
      out_q.visited_vertex <= '0;
      out_q.last_of_run    <= 1'b1;
      out_q.status         <= status_q;
    end else if (cmd_i.emit_vertex) begin
      out_q.visited_vertex <= 6'(cur_q);
      out_q.last_of_run    <= (back_q == front_q);
      out_q.status         <= gbt_pkg::ST_OK;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: rtl/gbt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph traversal controller
// State machine that sequences clears, edge inserts and walks.
// ----------------------------------------------------------------------------
module gbt_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  gbt_pkg::dp_sts_t sts_i,
  output gbt_pkg::dp_cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_DECODE    = 4'd1;
  localparam logic [3:0] S_ADD_WR_A  = 4'd2;
  localparam logic [3:0] S_ADD_RD_B  = 4'd3;
  localparam logic [3:0] S_ADD_WR_B  = 4'd4;
  localparam logic [3:0] S_EMIT_ST   = 4'd5;
  localparam logic [3:0] S_WALK_INIT = 4'd6;
  localparam logic [3:0] S_POP       = 4'd7;
  localparam logic [3:0] S_LATCH     = 4'd8;
  localparam logic [3:0] S_HEAD      = 4'd9;
  localparam logic [3:0] S_EDGE      = 4'd10;
  localparam logic [3:0] S_EMIT_V    = 4'd11;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.func)
          gbt_pkg::FUNC_CLEAR: begin
            cmd_o.clear_graph = 1'b1;
            cmd_o.status_ld   = 1'b1;
            cmd_o.status_val  = gbt_pkg::ST_OK;
            state_d           = S_EMIT_ST;
          end
          gbt_pkg::FUNC_ADD: begin
            if (sts_i.range_bad) begin
              cmd_o.status_ld  = 1'b1;
              cmd_o.status_val = gbt_pkg::ST_RANGE;
              state_d          = S_EMIT_ST;
            end else if (sts_i.pool_full) begin
              cmd_o.status_ld  = 1'b1;
              cmd_o.status_val = gbt_pkg::ST_FULL;
              state_d          = S_EMIT_ST;
            end else begin
              cmd_o.head_rd  = 1'b1;
              cmd_o.head_sel = gbt_pkg::HSEL_A;
              state_d        = S_ADD_WR_A;
            end
          end
          default: begin
            if (sts_i.start_bad) begin
              cmd_o.status_ld  = 1'b1;
              cmd_o.status_val = gbt_pkg::ST_RANGE;
              state_d          = S_EMIT_ST;
            end else begin
              state_d = S_WALK_INIT;
            end
          end
        endcase
      end
      S_ADD_WR_A: begin
        cmd_o.add_wr = 1'b1;
        state_d      = S_ADD_RD_B;
      end
      S_ADD_RD_B: begin
        cmd_o.head_rd  = 1'b1;
        cmd_o.head_sel = gbt_pkg::HSEL_B;
        state_d        = S_ADD_WR_B;
      end
      S_ADD_WR_B: begin
        cmd_o.add_wr     = 1'b1;
        cmd_o.add_wr_b   = 1'b1;
        cmd_o.status_ld  = 1'b1;
        cmd_o.status_val = gbt_pkg::ST_OK;
        state_d          = S_EMIT_ST;
      end
      S_EMIT_ST: begin
        if (sts_i.out_free) begin
          cmd_o.emit_status = 1'b1;
          state_d           = S_IDLE;
        end
      end
      S_WALK_INIT: begin
        cmd_o.walk_init = 1'b1;
        state_d         = S_POP;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.head_rd  = 1'b1;
        cmd_o.head_sel = gbt_pkg::HSEL_CUR;
        state_d        = S_HEAD;
      end
      S_HEAD: begin
        if (sts_i.head_null) begin
          state_d = S_EMIT_V;
        end else begin
          cmd_o.pool_rd_head = 1'b1;
          state_d            = S_EDGE;
        end
      end
      S_EDGE: begin
        cmd_o.edge_proc = 1'b1;
        if (sts_i.link_null) begin
          state_d = S_EMIT_V;
        end else begin
          cmd_o.pool_rd_link = 1'b1;
        end
      end
      S_EMIT_V: begin
        if (sts_i.out_free) begin
          cmd_o.emit_vertex = 1'b1;
          state_d           = sts_i.list_empty ? S_IDLE : S_POP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/graph_bfs_dfs_traversal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Graph BFS/DFS traversal engine
// Holds an undirected graph as neighbor lists and walks it breadth or depth
// first, streaming the visited vertices out in visit order.
// ----------------------------------------------------------------------------
// Usage: an input item (in_valid_i/in_stall_o) carries a function code and two
// vertex numbers. Clear and add edge each give one result item; a walk gives
// one result per reached vertex with last_of_run set on the final one. Errors
// give a single result with the status code set. Results leave on
// out_valid_o/out_data_o and are held while out_stall_i is high.
// The vertex count register is written through cfg_valid_i/cfg_data_i; the
// port is always ready and should be written only while the engine is idle.
// After decode, an edge insert reads and writes the list head of each end
// in turn; a walk marks its start vertex, then per visited vertex pops the
// work list, reads its list head and walks its neighbor list, each step
// a single registered read of the list head, edge pool or work list
// memory. The engine accepts one item at a time and stalls its input until
// the last result of the current item is in the output register.
// Reset clears the lists (per-vertex valid bits), the pool fill count and the
// visited marks, and sets the vertex count to 64; no clearing pass is needed.
// While the receiver stalls, the engine waits with the next result pending.
// ----------------------------------------------------------------------------
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES      = 64,
  parameter int EDGE_POOL_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  gbt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gbt_pkg::out_item_t out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [6:0]         cfg_data_i
);

  gbt_pkg::dp_cmd_t cmd;
  gbt_pkg::dp_sts_t sts;

  // The register write is a single flop update, so the port never pushes back.
  assign cfg_ready_o = 1'b1;

  // The controller steps through each item; it holds the input stalled
  // whenever it is not idle.
  gbt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath owns all storage and the output register.
  gbt_dp #(
    .MAX_VERTICES      (MAX_VERTICES),
    .EDGE_POOL_ENTRIES (EDGE_POOL_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
